// ===== rtl/core/ictf_pkg.sv =====
// ----------------------------------------------------------------------------
// ictf_pkg
// Shared constants, arctangent table, datapath command and status types.
// ----------------------------------------------------------------------------
package ictf_pkg;

    localparam int ANGLE_W      = 24;
    localparam int TIME_W       = 48;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 24;
    localparam int GYRO_STEPS   = 9;
    localparam int PREP_STEPS   = 3;
    localparam int BLEND_STEPS  = 5;
    localparam int STEP_W       = 5;
    localparam int MAG_W        = 41;
    localparam int CX_W         = 44;
    localparam int CA_W         = 28;

    localparam logic [MAG_W-1:0]       MAG_CAP     = 41'h100_0000_0000;
    localparam logic signed [CA_W-1:0] PI_Q24      = 28'sd52707179;
    localparam logic [ANGLE_W-1:0]     PI_Q16      = 24'd205887;
    localparam logic [15:0]            BLEND_RESET = 16'd64225;
    localparam logic [31:0]            T2S_RESET   = 32'd4294967;

    localparam logic CFG_BLEND = 1'b0;
    localparam logic CFG_T2S   = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT,
        OP_GYRO,
        OP_PREP,
        OP_SQRT,
        OP_CINIT,
        OP_CORD,
        OP_COUT,
        OP_FIRST,
        OP_BLEND,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] step;
        logic [1:0]        axis;
        logic              which;
    } ictf_cmd_t;

    typedef struct packed {
        logic is_accel;
        logic pose_set;
        logic out_free;
    } ictf_stat_t;

    function automatic logic signed [CA_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
        logic signed [CA_W-1:0] r;
        case (i)
            5'd0:  r = 28'sd13176795;
            5'd1:  r = 28'sd7778716;
            5'd2:  r = 28'sd4110060;
            5'd3:  r = 28'sd2086331;
            5'd4:  r = 28'sd1047214;
            5'd5:  r = 28'sd524117;
            5'd6:  r = 28'sd262123;
            5'd7:  r = 28'sd131069;
            5'd8:  r = 28'sd65536;
            5'd9:  r = 28'sd32768;
            5'd10: r = 28'sd16384;
            5'd11: r = 28'sd8192;
            5'd12: r = 28'sd4096;
            5'd13: r = 28'sd2048;
            5'd14: r = 28'sd1024;
            5'd15: r = 28'sd512;
            5'd16: r = 28'sd256;
            5'd17: r = 28'sd128;
            5'd18: r = 28'sd64;
            5'd19: r = 28'sd32;
            5'd20: r = 28'sd16;
            5'd21: r = 28'sd8;
            5'd22: r = 28'sd4;
            5'd23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/ictf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ictf_ctrl
// Sequencer for the tilt filter: walks gyro, square root, cordic and blend
// steps and issues at most one datapath command per cycle, none while waiting.
// ----------------------------------------------------------------------------
module ictf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ictf_pkg::ictf_stat_t stat,
    output ictf_pkg::ictf_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_KIND  = 11'b00000000010,
        ST_GYRO  = 11'b00000000100,
        ST_PREP  = 11'b00000001000,
        ST_SQRT  = 11'b00000010000,
        ST_CINIT = 11'b00000100000,
        ST_CORD  = 11'b00001000000,
        ST_COUT  = 11'b00010000000,
        ST_FIRST = 11'b00100000000,
        ST_BLEND = 11'b01000000000,
        ST_DONE  = 11'b10000000000
    } state_t;

    localparam int SW = ictf_pkg::STEP_W;

    state_t        state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [1:0]    axis_reg, axis_next;
    logic          which_reg, which_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        axis_next  = axis_reg;
        which_next = which_reg;
        cmd.op     = ictf_pkg::OP_NONE;
        cmd.step   = step_reg;
        cmd.axis   = axis_reg;
        cmd.which  = which_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = ictf_pkg::OP_LOAD;
                    state_next = ST_KIND;
                end
            end
            ST_KIND: begin
                step_next = '0;
                axis_next = '0;
                if (stat.is_accel) begin
                    state_next = ST_PREP;
                end else begin
                    cmd.op     = ictf_pkg::OP_DT;
                    state_next = stat.pose_set ? ST_GYRO : ST_DONE;
                end
            end
            ST_GYRO: begin
                cmd.op    = ictf_pkg::OP_GYRO;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(ictf_pkg::GYRO_STEPS - 1)) begin
                    step_next = '0;
                    axis_next = axis_reg + 1'b1;
                    if (axis_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PREP: begin
                cmd.op    = ictf_pkg::OP_PREP;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(ictf_pkg::PREP_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.op    = ictf_pkg::OP_SQRT;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(ictf_pkg::SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    which_next = 1'b0;
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.op     = ictf_pkg::OP_CINIT;
                step_next  = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                cmd.op    = ictf_pkg::OP_CORD;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(ictf_pkg::CORDIC_STEPS - 1)) begin
                    state_next = ST_COUT;
                end
            end
            ST_COUT: begin
                cmd.op    = ictf_pkg::OP_COUT;
                step_next = '0;
                if (!which_reg) begin
                    which_next = 1'b1;
                    state_next = ST_CINIT;
                end else begin
                    state_next = stat.pose_set ? ST_BLEND : ST_FIRST;
                end
            end
            ST_FIRST: begin
                cmd.op     = ictf_pkg::OP_FIRST;
                state_next = ST_DONE;
            end
            ST_BLEND: begin
                cmd.op    = ictf_pkg::OP_BLEND;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(ictf_pkg::BLEND_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = ictf_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            axis_reg  <= '0;
            which_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
            which_reg <= which_next;
        end
    end

    a_accept_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_KIND))
        else $error("accepted item did not start decoding");

    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && stat.out_free) |=> (state_reg == ST_IDLE))
        else $error("finished item not handed to output register");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GYRO) |-> (axis_reg != 2'd3))
        else $error("gyro axis counter out of range");

    a_cord_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (step_reg < SW'(ictf_pkg::CORDIC_STEPS)))
        else $error("cordic step counter out of range");

endmodule

// ===== rtl/core/ictf_dp.sv =====
// ----------------------------------------------------------------------------
// ictf_dp
// Datapath: angle state, shared multiplier, bit-serial square root and
// vectoring cordic, blend arithmetic and the output register.
// ----------------------------------------------------------------------------
module ictf_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ictf_pkg::ictf_cmd_t  cmd,
    output ictf_pkg::ictf_stat_t stat,
    input  logic [119:0]         s_tdata,
    input  logic                 s_tuser,
    input  logic [15:0]          blend_weight,
    input  logic [31:0]          tick_to_seconds,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,
    output logic                 m_tuser
);

    localparam int AW = ictf_pkg::ANGLE_W;
    localparam int TW = ictf_pkg::TIME_W;
    localparam int MW = ictf_pkg::MAG_W;
    localparam int XW = ictf_pkg::CX_W;
    localparam int CW = ictf_pkg::CA_W;

    function automatic logic [MW-1:0] cap(input logic [71:0] v);
        return (v > 72'(ictf_pkg::MAG_CAP)) ? ictf_pkg::MAG_CAP : v[MW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] sat(input logic signed [42:0] v);
        logic signed [42:0] hi;
        logic signed [42:0] lo;
        hi = 43'sd8388607;
        lo = -43'sd8388608;
        if (v > hi) return hi[AW-1:0];
        if (v < lo) return lo[AW-1:0];
        return v[AW-1:0];
    endfunction

    logic                    func_reg;
    logic signed [AW-1:0]    vx_reg, vy_reg, vz_reg;
    logic [TW-1:0]           time_reg, last_time_reg, dt_reg;
    logic signed [AW-1:0]    th_x_reg, th_y_reg, th_z_reg;
    logic                    pose_reg;
    logic signed [65:0]      prod_reg;
    logic [55:0]             m_reg, pc_reg;
    logic [31:0]             pa_reg;
    logic [MW-1:0]           low_reg, hi_reg, inc_reg;
    logic [TW-1:0]           rem_reg, res_reg;
    logic signed [XW-1:0]    cx_reg, cy_reg;
    logic signed [CW-1:0]    ca_reg;
    logic                    czero_reg;
    logic signed [AW-1:0]    ax_reg, az_reg;
    logic signed [42:0]      acc_reg;
    logic                    m_tvalid_reg;
    logic [71:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    mul_en;
    logic signed [32:0]      mul_a, mul_b;
    logic signed [AW-1:0]    rate;
    logic [AW-1:0]           rate_mag;
    logic signed [AW-1:0]    th_sel;
    logic [16:0]             wc;
    logic [TW-1:0]           sq_bit, sq_trial;
    logic [5:0]              sq_shift;
    logic signed [AW:0]      c_yv, c_xv;
    logic signed [XW-1:0]    c_x0, c_y0, c_dx, c_dy;
    logic signed [CW-1:0]    c_round;
    logic signed [AW-1:0]    c_res;
    logic signed [42:0]      g_inc, g_sum, b_sum;
    logic                    g_neg;

    always_comb begin
        unique case (cmd.axis)
            2'd0:    rate = vz_reg;
            2'd1:    rate = vy_reg;
            default: rate = vx_reg;
        endcase
        unique case (cmd.axis)
            2'd0:    th_sel = th_x_reg;
            2'd1:    th_sel = th_y_reg;
            default: th_sel = th_z_reg;
        endcase
    end

    assign rate_mag = rate[AW-1] ? (~rate + 1'b1) : rate;
    assign wc       = 17'h10000 - {1'b0, blend_weight};
    assign g_neg    = rate[AW-1] ^ (cmd.axis != 2'd2);
    assign g_inc    = $signed({2'b00, inc_reg});
    assign g_sum    = 43'(th_sel) + (g_neg ? -g_inc : g_inc);
    assign b_sum    = (acc_reg + $signed(prod_reg[42:0]) + 43'sd32768) >>> 16;

    assign sq_shift = 6'(2 * ictf_pkg::SQRT_STEPS - 2) - {cmd.step, 1'b0};
    assign sq_bit   = TW'(1) << sq_shift;
    assign sq_trial = res_reg + sq_bit;

    assign c_yv    = cmd.which ? 25'(vy_reg) : 25'(vx_reg);
    assign c_xv    = cmd.which ? 25'(vz_reg) : $signed({1'b0, res_reg[AW-1:0]});
    assign c_x0    = XW'(c_xv) <<< 16;
    assign c_y0    = XW'(c_yv) <<< 16;
    assign c_dx    = cy_reg >>> cmd.step;
    assign c_dy    = cx_reg >>> cmd.step;
    assign c_round = (ca_reg + 28'sd128) >>> 8;
    assign c_res   = czero_reg ? '0 : c_round[AW-1:0];

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            ictf_pkg::OP_GYRO: begin
                case (cmd.step)
                    5'd0: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({9'd0, rate_mag});
                        mul_b  = $signed({1'b0, tick_to_seconds});
                    end
                    5'd2: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({1'b0, m_reg[31:0]});
                        mul_b  = $signed({1'b0, dt_reg[31:0]});
                    end
                    5'd3: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({1'b0, m_reg[31:0]});
                        mul_b  = $signed({17'd0, dt_reg[47:32]});
                    end
                    5'd4: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({9'd0, m_reg[55:32]});
                        mul_b  = $signed({1'b0, dt_reg[31:0]});
                    end
                    5'd5: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({9'd0, m_reg[55:32]});
                        mul_b  = $signed({17'd0, dt_reg[47:32]});
                    end
                    default: begin
                        mul_en = 1'b0;
                    end
                endcase
            end
            ictf_pkg::OP_PREP: begin
                mul_en = (cmd.step != 5'd2);
                mul_a  = (cmd.step == 5'd0) ? 33'(vy_reg) : 33'(vz_reg);
                mul_b  = mul_a;
            end
            ictf_pkg::OP_BLEND: begin
                case (cmd.step)
                    5'd0: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({17'd0, blend_weight});
                        mul_b  = 33'(th_x_reg);
                    end
                    5'd1: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({16'd0, wc});
                        mul_b  = 33'(ax_reg);
                    end
                    5'd2: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({17'd0, blend_weight});
                        mul_b  = 33'(th_z_reg);
                    end
                    5'd3: begin
                        mul_en = 1'b1;
                        mul_a  = $signed({16'd0, wc});
                        mul_b  = 33'(az_reg);
                    end
                    default: begin
                        mul_en = 1'b0;
                    end
                endcase
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ictf_pkg::OP_LOAD: begin
                func_reg <= s_tuser;
                vx_reg   <= $signed(s_tdata[23:0]);
                vy_reg   <= $signed(s_tdata[47:24]);
                vz_reg   <= $signed(s_tdata[71:48]);
                time_reg <= s_tdata[119:72];
            end
            ictf_pkg::OP_DT: begin
                dt_reg <= time_reg - last_time_reg;
            end
            ictf_pkg::OP_GYRO: begin
                case (cmd.step)
                    5'd1: m_reg   <= prod_reg[55:0];
                    5'd3: pa_reg  <= prod_reg[63:32];
                    5'd4: low_reg <= cap(72'(cap(72'(prod_reg[47:0]))) + 72'(pa_reg));
                    5'd5: pc_reg  <= prod_reg[55:0];
                    5'd6: hi_reg  <= cap({1'b0, prod_reg[38:0], 32'd0} + 72'(pc_reg));
                    5'd7: inc_reg <= cap(72'(hi_reg) + 72'(low_reg));
                    default: begin
                    end
                endcase
            end
            ictf_pkg::OP_PREP: begin
                if (cmd.step == 5'd1) begin
                    rem_reg <= prod_reg[47:0];
                end else if (cmd.step == 5'd2) begin
                    rem_reg <= rem_reg + prod_reg[47:0];
                    res_reg <= '0;
                end
            end
            ictf_pkg::OP_SQRT: begin
                if (rem_reg >= sq_trial) begin
                    rem_reg <= rem_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end else begin
                    res_reg <= res_reg >> 1;
                end
            end
            ictf_pkg::OP_CINIT: begin
                czero_reg <= (c_xv == '0) && (c_yv == '0);
                if (c_xv < 0) begin
                    cx_reg <= -c_x0;
                    cy_reg <= -c_y0;
                    ca_reg <= (c_yv >= 0) ? ictf_pkg::PI_Q24 : -ictf_pkg::PI_Q24;
                end else begin
                    cx_reg <= c_x0;
                    cy_reg <= c_y0;
                    ca_reg <= '0;
                end
            end
            ictf_pkg::OP_CORD: begin
                if (!cy_reg[XW-1]) begin
                    cx_reg <= cx_reg + c_dx;
                    cy_reg <= cy_reg - c_dy;
                    ca_reg <= ca_reg + ictf_pkg::atan_q24(cmd.step);
                end else begin
                    cx_reg <= cx_reg - c_dx;
                    cy_reg <= cy_reg + c_dy;
                    ca_reg <= ca_reg - ictf_pkg::atan_q24(cmd.step);
                end
            end
            ictf_pkg::OP_COUT: begin
                if (cmd.which) begin
                    az_reg <= c_res;
                end else begin
                    ax_reg <= c_res;
                end
            end
            ictf_pkg::OP_BLEND: begin
                if (cmd.step == 5'd1 || cmd.step == 5'd3) begin
                    acc_reg <= prod_reg[42:0];
                end
            end
            ictf_pkg::OP_OUT: begin
                m_tdata_reg <= {th_z_reg, th_y_reg, th_x_reg};
                m_tuser_reg <= pose_reg;
            end
            default: begin
            end
        endcase
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_x_reg      <= '0;
            th_y_reg      <= '0;
            th_z_reg      <= '0;
            pose_reg      <= 1'b0;
            last_time_reg <= '0;
        end else begin
            case (cmd.op)
                ictf_pkg::OP_DT: begin
                    last_time_reg <= time_reg;
                end
                ictf_pkg::OP_GYRO: begin
                    if (cmd.step == 5'(ictf_pkg::GYRO_STEPS - 1)) begin
                        unique case (cmd.axis)
                            2'd0:    th_x_reg <= sat(g_sum);
                            2'd1:    th_y_reg <= sat(g_sum);
                            default: th_z_reg <= sat(g_sum);
                        endcase
                    end
                end
                ictf_pkg::OP_FIRST: begin
                    th_x_reg <= ax_reg;
                    th_y_reg <= ictf_pkg::PI_Q16;
                    th_z_reg <= az_reg;
                    pose_reg <= 1'b1;
                end
                ictf_pkg::OP_BLEND: begin
                    if (cmd.step == 5'd2) begin
                        th_x_reg <= sat(b_sum);
                    end else if (cmd.step == 5'd4) begin
                        th_z_reg <= sat(b_sum);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == ictf_pkg::OP_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;
    assign stat.is_accel = func_reg;
    assign stat.pose_set = pose_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== rtl/core/imu_complementary_tilt_filter.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary tilt filter fusing gyro rate and accelerometer items.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser says gyro (0) or accelerometer
// (1), tdata carries the vector and the gyro timestamp. Each accepted item
// gives exactly one result item on the m_ stream with the three current
// angles and the pose-set flag.
// One item is processed at a time. A gyro item runs three axes of nine steps
// on the shared 33x33 multiplier once the pose is set. An accelerometer item
// runs 24 square-root steps, two 16-step cordic runs and 1 pose step the first
// time or 5 blend steps after.
// Results sit in an output register; the next item is taken as soon as the
// previous result is parked there, so a stalled receiver only holds the
// sequencer once a second result is ready.
// Reset clears the angles, the pose flag and the timestamp, and loads the
// default blend weight and tick period. Configuration sits on the APB port:
// blend weight at 0x0, tick period at 0x4. They are to be written by the user
// only while idle; the block itself has no check for it.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // vec_x, vec_y, vec_z, sample_time
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // angle_x, angle_y, angle_z
    output logic         m_tuser,   // initialized
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0]          blend_reg;
    logic [31:0]          t2s_reg;
    logic                 cfg_wr;
    ictf_pkg::ictf_cmd_t  cmd;
    ictf_pkg::ictf_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ictf_pkg::CFG_T2S) ? t2s_reg : {16'd0, blend_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_reg <= ictf_pkg::BLEND_RESET;
            t2s_reg   <= ictf_pkg::T2S_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == ictf_pkg::CFG_BLEND) begin
                blend_reg <= pwdata[15:0];
            end else begin
                t2s_reg <= pwdata;
            end
        end
    end

    ictf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ictf_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .blend_weight    (blend_reg),
        .tick_to_seconds (t2s_reg),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complementary tilt filter.
// ----------------------------------------------------------------------------
// Gyro and accelerometer items are driven on the input stream, while the
// receiver stalls at random. A bit-exact predictor computes the expected
// angles for every accepted item and a scoreboard compares each result. The
// blend weight and tick period are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    typedef struct packed {
        logic        init;
        logic [23:0] az;
        logic [23:0] ay;
        logic [23:0] ax;
    } angle_res_t;

    int errors = 0;
    longint cycles = 0;
    bit rx_idle_en = 1'b1;

    imu_complementary_tilt_filter i_dut (.*);

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    class tilt_scoreboard;
        longint unsigned weight, tick;
        longint th_x, th_y, th_z;
        bit pose;
        longint unsigned last_t;
        angle_res_t pending[$];

        function void reset_state();
            weight = ictf_pkg::BLEND_RESET; tick = ictf_pkg::T2S_RESET;
            th_x = 0; th_y = 0; th_z = 0; pose = 0; last_t = 0;
        endfunction

        function longint sat(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        function longint unsigned cap_mul(longint unsigned a, longint unsigned b);
            longint unsigned cap;
            cap = 64'd1 << 40;
            if (a == 0 || b == 0) return 0;
            if (a > cap / b) return cap;
            return (a * b > cap) ? cap : a * b;
        endfunction

        function longint unsigned cap_add(longint unsigned a, longint unsigned b);
            longint unsigned cap;
            cap = 64'd1 << 40;
            return (a + b > cap) ? cap : a + b;
        endfunction

        function longint rate_step(longint rate, longint unsigned dt);
            longint unsigned mag, m, d, lo;
            mag = (rate < 0) ? -rate : rate;
            m = mag * tick;
            lo = cap_add(cap_mul(m & 32'hFFFFFFFF, dt >> 32),
                         ((m & 32'hFFFFFFFF) * (dt & 32'hFFFFFFFF)) >> 32);
            d = cap_add(cap_mul(m >> 32, dt), lo);
            return (rate < 0) ? -longint'(d) : longint'(d);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint atan_tab(int i);
            longint t[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                              262123, 131069, 65536, 32768, 16384, 8192, 4096,
                              2048, 1024, 512};
            return t[i];
        endfunction

        function longint cordic_atan2(longint yv, longint xv);
            longint x, y, a, dx, dy;
            x = xv * 65536; y = yv * 65536; a = 0;
            if (xv == 0 && yv == 0) return 0;
            if (x < 0) begin
                x = -x; y = -y;
                a = (yv >= 0) ? longint'(ictf_pkg::PI_Q24) : -longint'(ictf_pkg::PI_Q24);
            end
            for (int i = 0; i < ictf_pkg::CORDIC_STEPS; i++) begin
                dx = fshr(y, i); dy = fshr(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; a += atan_tab(i);
                end else begin
                    x -= dx; y += dy; a -= atan_tab(i);
                end
            end
            return fshr(a + 128, 8);
        endfunction

        function void note_input(bit accel, logic signed [23:0] vx,
                                 logic signed [23:0] vy, logic signed [23:0] vz,
                                 logic [47:0] t);
            longint ax, az, w, wc;
            longint unsigned dt;
            angle_res_t r;
            if (!accel) begin
                if (pose) begin
                    dt = (t - last_t) & 48'hFFFFFFFFFFFF;
                    th_x = sat(th_x - rate_step(vz, dt));
                    th_y = sat(th_y - rate_step(vy, dt));
                    th_z = sat(th_z + rate_step(vx, dt));
                end
                last_t = t;
            end else begin
                ax = cordic_atan2(vx, longint'(int_sqrt(longint'(vy) * vy
                                                        + longint'(vz) * vz)));
                az = cordic_atan2(vy, vz);
                if (!pose) begin
                    pose = 1; th_x = sat(ax); th_z = sat(az); th_y = ictf_pkg::PI_Q16;
                end else begin
                    w = weight; wc = 65536 - w;
                    th_x = sat(fshr(w * th_x + wc * ax + 32768, 16));
                    th_z = sat(fshr(w * th_z + wc * az + 32768, 16));
                end
            end
            r.ax = th_x[23:0]; r.ay = th_y[23:0]; r.az = th_z[23:0]; r.init = pose;
            pending.push_back(r);
        endfunction

        task check_result(angle_res_t got);
            angle_res_t e;
            if (pending.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.ax !== e.ax) report($sformatf("angle_x %h exp %h", got.ax, e.ax));
            if (got.ay !== e.ay) report($sformatf("angle_y %h exp %h", got.ay, e.ay));
            if (got.az !== e.az) report($sformatf("angle_z %h exp %h", got.az, e.az));
            if (got.init !== e.init) report($sformatf("initialized %b exp %b",
                                                      got.init, e.init));
        endtask
    endclass

    tilt_scoreboard sb = new();

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(posedge aclk);
                @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tuser, m_tdata[71:48], m_tdata[47:24], m_tdata[23:0]});
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == ictf_pkg::CFG_BLEND) sb.weight = val[15:0];
        else sb.tick = val;
    endtask

    task automatic send_item(input bit accel, input logic [23:0] vx, input logic [23:0] vy,
                             input logic [23:0] vz, input logic [47:0] t, input bit gaps);
        int n;
        @(posedge aclk);
        if (gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tuser <= accel; s_tdata <= {t, vz, vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(accel, vx, vy, vz, t);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [23:0] rnd_vec();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(0, 262144)) - 131072);
            3: return 24'(int'($urandom_range(0, 4096)) - 2048);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        logic [47:0] t;
        sb.reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // gyro before pose, then first accel
        send_item(0, 24'h7FFFFF, 24'h800000, 24'h001000, 48'd5, 0);
        send_item(1, 24'd0, 24'd0, 24'd0, 48'hFFFFFFFFFFFF, 0);
        send_item(1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 48'd0, 0);
        send_item(1, 24'h800000, 24'h7FFFFF, 24'h800000, 48'd0, 0);
        send_item(1, 24'd0, 24'd65536, 24'hFF0000, 48'd0, 0);
        send_item(0, 24'd65536, 24'hFF0000, 24'd3000, 48'd1005, 0);
        send_item(0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 48'd1000, 0);
        send_item(0, 24'h800000, 24'h7FFFFF, 24'h800000, 48'hFFFFFFFFFFFF, 0);
        send_item(0, 24'h000100, 24'h000100, 24'h000100, 48'hFFFFFFFFFFFF, 0);
        drain();
        reg_write(ictf_pkg::CFG_T2S, 32'd0);
        send_item(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 48'd12345, 0);
        drain();
        reg_write(ictf_pkg::CFG_BLEND, 32'd0);
        reg_write(ictf_pkg::CFG_T2S, 32'hFFFFFFFF);
        send_item(1, 24'd1000, 24'd2000, 24'd3000, 48'd0, 0);
        send_item(0, 24'd1, 24'hFFFFFF, 24'd2, 48'd12346, 0);
        drain();
        reg_write(ictf_pkg::CFG_BLEND, 32'h0000FFFF);
        send_item(1, 24'hFFF000, 24'h001000, 24'h800000, 48'd0, 0);
        drain();
        t = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    reg_write(ictf_pkg::CFG_BLEND, 32'(ictf_pkg::BLEND_RESET));
                    reg_write(ictf_pkg::CFG_T2S, ictf_pkg::T2S_RESET);
                end
                1: begin
                    reg_write(ictf_pkg::CFG_BLEND, $urandom);
                    reg_write(ictf_pkg::CFG_T2S, $urandom);
                end
                2: begin
                    reg_write(ictf_pkg::CFG_BLEND, 32'd0);
                    reg_write(ictf_pkg::CFG_T2S, 32'd1);
                end
                3: begin
                    reg_write(ictf_pkg::CFG_BLEND, 32'h0000FFFF);
                    reg_write(ictf_pkg::CFG_T2S, $urandom_range(1, 100000));
                end
                default: begin
                    reg_write(ictf_pkg::CFG_BLEND, $urandom);
                    reg_write(ictf_pkg::CFG_T2S, $urandom);
                    rx_idle_en = 1'b0;
                end
            endcase
            for (int k = 0; k < 200; k++) begin
                case ($urandom_range(0, 9))
                    0: t = 48'({$urandom, $urandom});
                    1: t = t - 48'($urandom_range(0, 50));
                    default: t = t + 48'($urandom_range(0, 200));
                endcase
                send_item($urandom_range(0, 2) == 0, rnd_vec(), rnd_vec(), rnd_vec(), t,
                          ph != 4);
            end
            drain();
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/ictf_pkg.sv
rtl/core/ictf_ctrl.sv
rtl/core/ictf_dp.sv
rtl/core/imu_complementary_tilt_filter.sv
tb/tb_top.sv
